[rtl/pnge_pkg.sv]
// shared types, codes and byte tables of the png gray8 stored encoder
package pnge_pkg;

    localparam logic [3:0] SEL_CONST   = 4'd0;
    localparam logic [3:0] SEL_WIDTH   = 4'd1;
    localparam logic [3:0] SEL_HEIGHT  = 4'd2;
    localparam logic [3:0] SEL_IDATLEN = 4'd3;
    localparam logic [3:0] SEL_CRC     = 4'd4;
    localparam logic [3:0] SEL_ADLER   = 4'd5;
    localparam logic [3:0] SEL_BLKHDR  = 4'd6;
    localparam logic [3:0] SEL_FILTER  = 4'd7;
    localparam logic [3:0] SEL_PIXEL   = 4'd8;

    localparam logic       OP_BEGIN = 1'b0;
    localparam logic       CFG_WIDTH  = 1'b0;
    localparam logic       CFG_HEIGHT = 1'b1;

    localparam int BEGIN_BYTES = 43;
    localparam int TRAIL_BYTES = 20;

    typedef struct packed {
        logic       emit;
        logic [3:0] sel;
        logic [2:0] idx;
        logic [7:0] konst;
        logic       in_crc;
        logic       crc_init;
        logic       last;
        logic       eoi;
        logic       start;
        logic       take_pix;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic fill_zero;
        logic col_zero;
        logic raw_one;
    } t_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? 32'hedb88320 : 32'd0);
        end
        return r;
    endfunction

    function automatic t_cmd mk(input logic [3:0] sel, input logic [2:0] idx,
                                input logic [7:0] k, input logic crc, input logic init);
        t_cmd c;
        c = '0;
        c.emit = 1'b1;
        c.sel = sel;
        c.idx = idx;
        c.konst = k;
        c.in_crc = crc;
        c.crc_init = init;
        return c;
    endfunction

    function automatic t_cmd begin_step(input logic [5:0] i);
        t_cmd c;
        case (i)
            6'd0:  c = mk(SEL_CONST, 3'd0, 8'd137, 1'b0, 1'b0);
            6'd1:  c = mk(SEL_CONST, 3'd0, 8'd80, 1'b0, 1'b0);
            6'd2:  c = mk(SEL_CONST, 3'd0, 8'd78, 1'b0, 1'b0);
            6'd3:  c = mk(SEL_CONST, 3'd0, 8'd71, 1'b0, 1'b0);
            6'd4:  c = mk(SEL_CONST, 3'd0, 8'd13, 1'b0, 1'b0);
            6'd5:  c = mk(SEL_CONST, 3'd0, 8'd10, 1'b0, 1'b0);
            6'd6:  c = mk(SEL_CONST, 3'd0, 8'd26, 1'b0, 1'b0);
            6'd7:  c = mk(SEL_CONST, 3'd0, 8'd10, 1'b0, 1'b0);
            6'd8, 6'd9, 6'd10: c = mk(SEL_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
            6'd11: c = mk(SEL_CONST, 3'd0, 8'd13, 1'b0, 1'b0);
            6'd12: c = mk(SEL_CONST, 3'd0, 8'd73, 1'b1, 1'b1);
            6'd13: c = mk(SEL_CONST, 3'd0, 8'd72, 1'b1, 1'b0);
            6'd14: c = mk(SEL_CONST, 3'd0, 8'd68, 1'b1, 1'b0);
            6'd15: c = mk(SEL_CONST, 3'd0, 8'd82, 1'b1, 1'b0);
            6'd16, 6'd17, 6'd18, 6'd19:
                c = mk(SEL_WIDTH, 3'(i - 6'd16), 8'd0, 1'b1, 1'b0);
            6'd20, 6'd21, 6'd22, 6'd23:
                c = mk(SEL_HEIGHT, 3'(i - 6'd20), 8'd0, 1'b1, 1'b0);
            6'd24: c = mk(SEL_CONST, 3'd0, 8'd8, 1'b1, 1'b0);
            6'd25, 6'd26, 6'd27, 6'd28: c = mk(SEL_CONST, 3'd0, 8'd0, 1'b1, 1'b0);
            6'd29, 6'd30, 6'd31, 6'd32:
                c = mk(SEL_CRC, 3'(i - 6'd29), 8'd0, 1'b0, 1'b0);
            6'd33, 6'd34, 6'd35, 6'd36:
                c = mk(SEL_IDATLEN, 3'(i - 6'd33), 8'd0, 1'b0, 1'b0);
            6'd37: c = mk(SEL_CONST, 3'd0, 8'd73, 1'b1, 1'b1);
            6'd38: c = mk(SEL_CONST, 3'd0, 8'd68, 1'b1, 1'b0);
            6'd39: c = mk(SEL_CONST, 3'd0, 8'd65, 1'b1, 1'b0);
            6'd40: c = mk(SEL_CONST, 3'd0, 8'd84, 1'b1, 1'b0);
            6'd41: c = mk(SEL_CONST, 3'd0, 8'h78, 1'b1, 1'b0);
            6'd42: begin
                c = mk(SEL_CONST, 3'd0, 8'h01, 1'b1, 1'b0);
                c.last = 1'b1;
            end
            default: c = mk(SEL_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
        endcase
        return c;
    endfunction

    function automatic t_cmd trail_step(input logic [5:0] i);
        t_cmd c;
        case (i)
            6'd0, 6'd1, 6'd2, 6'd3: c = mk(SEL_ADLER, 3'(i), 8'd0, 1'b1, 1'b0);
            6'd4, 6'd5, 6'd6, 6'd7: c = mk(SEL_CRC, 3'(i - 6'd4), 8'd0, 1'b0, 1'b0);
            6'd8, 6'd9, 6'd10, 6'd11: c = mk(SEL_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
            6'd12: c = mk(SEL_CONST, 3'd0, 8'd73, 1'b1, 1'b1);
            6'd13: c = mk(SEL_CONST, 3'd0, 8'd69, 1'b1, 1'b0);
            6'd14: c = mk(SEL_CONST, 3'd0, 8'd78, 1'b1, 1'b0);
            6'd15: c = mk(SEL_CONST, 3'd0, 8'd68, 1'b1, 1'b0);
            6'd16, 6'd17, 6'd18: c = mk(SEL_CRC, 3'(i - 6'd16), 8'd0, 1'b0, 1'b0);
            6'd19: begin
                c = mk(SEL_CRC, 3'd3, 8'd0, 1'b0, 1'b0);
                c.last = 1'b1;
                c.eoi = 1'b1;
            end
            default: c = mk(SEL_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
        endcase
        return c;
    endfunction

endpackage

[rtl/png_gray8_stored_encoder.sv]
// png encoder for 8-bit gray pixels using stored deflate blocks, top level
// begin request: 43 output bytes at one per cycle unless the master side stalls
// pixel request: 1 to 7 bytes (0 with no open frame), plus 20 trailer bytes on the last pixel
// byte sequencer: one byte per cycle unless stalled, output register before the master side
// synchronous active-low reset: idle, no frame open, width and height registers at 1000
module png_gray8_stored_encoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // last_of_run
    output logic        m_axis_tuser    // end_of_image
);
    import pnge_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pnge_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pnge_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_eoi   (m_axis_tuser)
    );

    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of image without last");

    a_begin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_BEGIN |=> !s_axis_tready)
        else $error("ready right after begin");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("byte emitted into full output register");

endmodule

[rtl/pnge_ctrl.sv]
// sequencer that steps through the bytes of each request
module pnge_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    input  pnge_pkg::t_status i_status,
    output pnge_pkg::t_cmd   o_cmd
);
    import pnge_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BEGIN = 2'd1;
    localparam logic [1:0] ST_RAW   = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    logic [1:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [2:0] r_hdr, n_hdr;
    logic       r_filt, n_filt;
    logic       r_active, n_active;
    logic       w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_hdr = r_hdr;
        n_filt = r_filt;
        n_active = r_active;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_op == OP_BEGIN) begin
                        o_cmd.start = 1'b1;
                        n_state = ST_BEGIN;
                        n_cnt = '0;
                        n_active = 1'b1;
                    end else if (r_active) begin
                        o_cmd.take_pix = 1'b1;
                        n_filt = i_status.col_zero;
                        n_hdr = '0;
                        n_state = ST_RAW;
                    end
                end
            end
            ST_BEGIN: begin
                if (i_status.out_free) begin
                    o_cmd = begin_step(r_cnt);
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(BEGIN_BYTES - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RAW: begin
                if (i_status.out_free) begin
                    if (i_status.fill_zero) begin
                        o_cmd = mk(SEL_BLKHDR, r_hdr, 8'd0, 1'b1, 1'b0);
                        n_hdr = r_hdr + 3'd1;
                    end else if (r_filt) begin
                        o_cmd = mk(SEL_FILTER, 3'd0, 8'd0, 1'b1, 1'b0);
                        n_filt = 1'b0;
                        n_hdr = '0;
                    end else begin
                        o_cmd = mk(SEL_PIXEL, 3'd0, 8'd0, 1'b1, 1'b0);
                        o_cmd.last = !i_status.raw_one;
                        if (i_status.raw_one) begin
                            n_state = ST_TRAIL;
                            n_cnt = '0;
                            n_active = 1'b0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_TRAIL: begin
                if (i_status.out_free) begin
                    o_cmd = trail_step(r_cnt);
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'(TRAIL_BYTES - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_hdr <= '0;
            r_filt <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_hdr <= n_hdr;
            r_filt <= n_filt;
            r_active <= n_active;
        end
    end

endmodule

[rtl/pnge_dpath.sv]
// counters, checksums, byte select and output register
module pnge_dpath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [12:0]       i_cfg_data,
    input  logic [7:0]        i_pixel,
    input  pnge_pkg::t_cmd    i_cmd,
    output pnge_pkg::t_status o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic              o_out_eoi
);
    import pnge_pkg::*;

    logic [12:0] r_cfg_w, r_cfg_h, r_fw, r_fh, r_col, w_fw, w_fh;
    logic [26:0] r_raw, r_raw_left;
    logic [27:0] w_t;
    logic [27:0] r_blocks;
    logic [31:0] r_idatlen, r_crc, w_crc_in, w_word;
    logic [15:0] r_fill, r_alo, r_ahi, w_len, w_alo, w_ahi;
    logic [16:0] w_alo_s, w_ahi_s;
    logic [2:0]  r_st;
    logic [7:0]  r_pix, w_byte;
    logic        w_data;

    always_comb begin
        if (r_cfg_w == 13'd0) w_fw = 13'd1;
        else if ({3'd0, r_cfg_w} > 16'(MAX_WIDTH)) w_fw = 13'(MAX_WIDTH);
        else w_fw = r_cfg_w;
        if (r_cfg_h == 13'd0) w_fh = 13'd1;
        else if ({3'd0, r_cfg_h} > 16'(MAX_HEIGHT)) w_fh = 13'(MAX_HEIGHT);
        else w_fh = r_cfg_h;
    end

    assign w_t = {1'b0, r_raw} + 28'd65534;
    assign w_len = (r_raw_left > 27'd65535) ? 16'hffff : r_raw_left[15:0];

    always_comb begin
        case (i_cmd.sel)
            SEL_WIDTH:   w_word = {19'd0, r_fw};
            SEL_HEIGHT:  w_word = {19'd0, r_fh};
            SEL_IDATLEN: w_word = r_idatlen;
            SEL_CRC:     w_word = ~r_crc;
            SEL_ADLER:   w_word = {r_ahi, r_alo};
            default:     w_word = 32'd0;
        endcase
        case (i_cmd.sel)
            SEL_WIDTH, SEL_HEIGHT, SEL_IDATLEN, SEL_CRC, SEL_ADLER:
                w_byte = 8'(w_word >> (5'd24 - {i_cmd.idx[1:0], 3'd0}));
            SEL_BLKHDR: begin
                case (i_cmd.idx)
                    3'd0:    w_byte = {7'd0, (r_raw_left <= 27'd65535)};
                    3'd1:    w_byte = w_len[7:0];
                    3'd2:    w_byte = w_len[15:8];
                    3'd3:    w_byte = ~w_len[7:0];
                    default: w_byte = ~w_len[15:8];
                endcase
            end
            SEL_FILTER:  w_byte = 8'd0;
            SEL_PIXEL:   w_byte = r_pix;
            default:     w_byte = i_cmd.konst;
        endcase
    end

    assign w_data = i_cmd.emit && (i_cmd.sel == SEL_FILTER || i_cmd.sel == SEL_PIXEL);
    assign w_crc_in = i_cmd.crc_init ? 32'hffffffff : r_crc;
    assign w_alo_s = {1'b0, r_alo} + {9'd0, w_byte};
    assign w_alo = (w_alo_s >= 17'd65521) ? 16'(w_alo_s - 17'd65521) : w_alo_s[15:0];
    assign w_ahi_s = {1'b0, r_ahi} + {1'b0, w_alo};
    assign w_ahi = (w_ahi_s >= 17'd65521) ? 16'(w_ahi_s - 17'd65521) : w_ahi_s[15:0];

    assign o_status.out_free = !o_out_valid || i_out_ready;
    assign o_status.fill_zero = (r_fill == 16'd0);
    assign o_status.col_zero = (r_col == 13'd0);
    assign o_status.raw_one = (r_raw_left == 27'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 13'd1000;
            r_cfg_h <= 13'd1000;
            r_st <= '0;
            o_out_valid <= 1'b0;
            r_crc <= 32'hffffffff;
            r_alo <= 16'd1;
            r_ahi <= 16'd0;
            r_col <= '0;
            r_fill <= '0;
            r_raw_left <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == {1'b0, CFG_WIDTH}) r_cfg_w <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == {1'b0, CFG_HEIGHT}) r_cfg_h <= i_cfg_data;
            r_st <= {r_st[1:0], i_cmd.start};
            if (i_cmd.start) begin
                r_alo <= 16'd1;
                r_ahi <= 16'd0;
                r_col <= '0;
                r_fill <= '0;
            end
            if (r_st[1]) r_raw_left <= r_raw;
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                if (i_cmd.in_crc) r_crc <= crc_byte(w_crc_in, w_byte);
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.emit && i_cmd.sel == SEL_BLKHDR && i_cmd.idx == 3'd4) r_fill <= w_len;
            if (w_data) begin
                r_alo <= w_alo;
                r_ahi <= w_ahi;
                r_fill <= r_fill - 16'd1;
                r_raw_left <= r_raw_left - 27'd1;
            end
            if (i_cmd.emit && i_cmd.sel == SEL_PIXEL) begin
                if ({1'b0, r_col} + 14'd1 >= {1'b0, r_fw}) r_col <= '0;
                else r_col <= r_col + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_fw <= w_fw;
            r_fh <= w_fh;
        end
        if (i_cmd.take_pix) r_pix <= i_pixel;
        if (r_st[0]) r_raw <= 27'(({1'b0, r_fw} + 14'd1) * {1'b0, r_fh});
        if (r_st[1]) r_blocks <= (w_t + (w_t >> 16) + 28'd1) >> 16;
        if (r_st[2]) r_idatlen <= 32'(r_raw) + 32'(r_blocks) * 32'd5 + 32'd6;
        if (i_cmd.emit) begin
            o_out_byte <= w_byte;
            o_out_last <= i_cmd.last;
            o_out_eoi <= i_cmd.eoi;
        end
    end

endmodule

[bench/png_gray8_stored_encoder_tb.sv]
// testbench for png_gray8_stored_encoder: directed table, then random frames
`timescale 1ns / 100ps

module png_gray8_stored_encoder_tb;
    import pnge_pkg::*;

    localparam logic       OP_PIXEL  = ~OP_BEGIN;
    localparam logic [1:0] REG_WIDTH  = {1'b0, CFG_WIDTH};
    localparam logic [1:0] REG_HEIGHT = {1'b0, CFG_HEIGHT};
    localparam logic [1:0] REG_BAD_LO = 2'd2;
    localparam logic [1:0] REG_BAD_HI = 2'd3;
    localparam int         DIM_MAX    = 4096;
    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {CHK_NONE, CHK_FIRST, CHK_EMPTY} t_row_chk;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [12:0] data;
        logic        op;
        logic [7:0]  pix;
        t_row_chk    chk;
        logic [7:0]  first;
    } t_row;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       eoi;
    } t_png_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // pixel
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // out_byte
    logic        m_axis_tlast;        // last_of_run
    logic        m_axis_tuser;        // end_of_image

    png_gray8_stored_encoder u_top (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [12:0] reg_w = 13'd1000, reg_h = 13'd1000;
    logic [31:0] crc_run;
    int unsigned sum_lo, sum_hi, fw, fh, col, blk_left, raw_left;
    bit          frame_open;
    int          item_bytes;
    logic [7:0]  item_first;

    t_png_byte   png_q[$];
    t_row        dir_tab[$];
    int          errors, items, bytes_seen, frames_done, abandons, strays;
    bit          idle_on = 1'b1;
    bit          held;

    function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? 32'hedb88320 : 32'd0);
        return r;
    endfunction

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        if (v == 0) return 1;
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic void put(input logic [7:0] b, input bit in_crc);
        t_png_byte e;
        if (in_crc) crc_run = crc8(crc_run, b);
        e.data = b;
        e.last = 1'b0;
        e.eoi = 1'b0;
        png_q.push_back(e);
    endfunction

    function automatic void put32(input logic [31:0] v, input bit in_crc);
        for (int s = 24; s >= 0; s -= 8) put(v[s +: 8], in_crc);
    endfunction

    function automatic void put_tag(input logic [31:0] tag);
        crc_run = '1;
        put32(tag, 1'b1);
    endfunction

    function automatic void raw_out(input logic [7:0] b);
        int unsigned len;
        if (blk_left == 0) begin
            len = (raw_left > 65535) ? 65535 : raw_left;
            put((raw_left <= 65535) ? 8'd1 : 8'd0, 1'b1);
            put(len[7:0], 1'b1);
            put(len[15:8], 1'b1);
            put(~len[7:0], 1'b1);
            put(~len[15:8], 1'b1);
            blk_left = len;
        end
        put(b, 1'b1);
        sum_lo += b;
        if (sum_lo >= 65521) sum_lo -= 65521;
        sum_hi += sum_lo;
        if (sum_hi >= 65521) sum_hi -= 65521;
        blk_left--;
        raw_left--;
    endfunction

    function automatic void encode_item(input logic op, input logic [7:0] px);
        int unsigned raw, nblk;
        int          n0;
        n0 = png_q.size();
        if (op == OP_BEGIN) begin
            fw = clamp_dim(reg_w);
            fh = clamp_dim(reg_h);
            raw = (fw + 1) * fh;
            nblk = (raw + 65534) / 65535;
            foreach (PNG_SIG[i]) put(PNG_SIG[i], 1'b0);
            put32(32'd13, 1'b0);
            put_tag("IHDR");
            put32(fw, 1'b1);
            put32(fh, 1'b1);
            put(8'd8, 1'b1);
            for (int i = 0; i < 4; i++) put(8'd0, 1'b1);
            put32(~crc_run, 1'b0);
            put32(2 + raw + 5 * nblk + 4, 1'b0);
            put_tag("IDAT");
            put(8'h78, 1'b1);
            put(8'h01, 1'b1);
            sum_lo = 1;
            sum_hi = 0;
            col = 0;
            blk_left = 0;
            raw_left = raw;
            frame_open = 1'b1;
        end else if (frame_open) begin
            if (col == 0) raw_out(8'd0);
            raw_out(px);
            col++;
            if (col >= fw) col = 0;
            if (raw_left == 0) begin
                put32({sum_hi[15:0], sum_lo[15:0]}, 1'b1);
                put32(~crc_run, 1'b0);
                put32(32'd0, 1'b0);
                put_tag("IEND");
                put32(~crc_run, 1'b0);
                png_q[png_q.size() - 1].eoi = 1'b1;
                frame_open = 1'b0;
                frames_done++;
            end
        end
        if (png_q.size() > n0) png_q[png_q.size() - 1].last = 1'b1;
        item_bytes = png_q.size() - n0;
        item_first = (item_bytes > 0) ? png_q[n0].data : 8'd0;
    endfunction

    task automatic send(input logic op, input logic [7:0] px);
        int gap;
        bit rdy;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= px;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        encode_item(op, px);
        items++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (png_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) reg_w = val;
        else if (idx == REG_HEIGHT) reg_h = val;
    endtask

    function automatic void add_row(input t_row_kind k, input logic [1:0] idx,
                                    input logic [12:0] d, input logic op,
                                    input logic [7:0] px, input t_row_chk c,
                                    input logic [7:0] f);
        t_row r;
        r = '{k, idx, d, op, px, c, f};
        dir_tab.push_back(r);
    endfunction

    // output side: random stalls, one long hold-off
    initial begin
        t_png_byte e;
        bit v;
        logic [7:0] d;
        logic l, u;
        int stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 13) : 0;
            if (bytes_seen >= 150 && !held) begin
                held = 1'b1;
                stall = 400;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                v = m_axis_tvalid;
                d = m_axis_tdata;
                l = m_axis_tlast;
                u = m_axis_tuser;
                @(posedge i_clk);
            end while (!v);
            bytes_seen++;
            if (png_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte %02h last %b eoi %b", $time, d, l, u);
            end else begin
                e = png_q.pop_front();
                if (e.data !== d || e.last !== l || e.eoi !== u) begin
                    errors++;
                    $display("%0t: expected %02h/%b/%b, got %02h/%b/%b", $time,
                             e.data, e.last, e.eoi, d, l, u);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int unsigned w, h, npix, cut;
        crc_run = '1;
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h5a, CHK_EMPTY, '0);
        add_row(ROW_ITEM, '0, '0, OP_BEGIN, 8'hff, CHK_FIRST, 8'd137);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h00, CHK_FIRST, 8'd0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'hff, CHK_FIRST, 8'hff);
        add_row(ROW_ITEM, '0, '0, OP_BEGIN, 8'h00, CHK_FIRST, 8'd137);
        add_row(ROW_CFG, REG_WIDTH, 13'd0, '0, '0, CHK_NONE, '0);
        add_row(ROW_CFG, REG_HEIGHT, 13'd0, '0, '0, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_BEGIN, 8'h00, CHK_FIRST, 8'd137);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'hff, CHK_FIRST, 8'd1);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h07, CHK_EMPTY, '0);
        add_row(ROW_CFG, REG_BAD_LO, 13'h1fff, '0, '0, CHK_NONE, '0);
        add_row(ROW_CFG, REG_BAD_HI, 13'd5, '0, '0, CHK_NONE, '0);
        add_row(ROW_CFG, REG_WIDTH, 13'd3, '0, '0, CHK_NONE, '0);
        add_row(ROW_CFG, REG_HEIGHT, 13'd2, '0, '0, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_BEGIN, 8'h00, CHK_FIRST, 8'd137);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h00, CHK_FIRST, 8'd1);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'hff, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'haa, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h55, CHK_FIRST, 8'd0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h80, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h01, CHK_NONE, '0);
        add_row(ROW_ITEM, '0, '0, OP_PIXEL, 8'h7f, CHK_EMPTY, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send(dir_tab[i].op, dir_tab[i].pix);
                if (dir_tab[i].chk == CHK_EMPTY && item_bytes != 0) begin
                    errors++;
                    $display("%0t: expected no bytes, predicted %0d", $time, item_bytes);
                end else if (dir_tab[i].chk == CHK_FIRST &&
                             item_first !== dir_tab[i].first) begin
                    errors++;
                    $display("%0t: expected first byte %02h, predicted %02h", $time,
                             dir_tab[i].first, item_first);
                end
            end
        end

        while (items < 170) begin
            settle();
            idle_on = ($urandom_range(0, 3) != 0);
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? 0 : 1;
            if ($urandom_range(0, 1)) begin
                write_reg(REG_WIDTH, 13'(w));
                write_reg(REG_HEIGHT, 13'(h));
            end else begin
                write_reg(REG_HEIGHT, 13'(h));
                write_reg(REG_WIDTH, 13'(w));
            end
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_BAD_LO : REG_BAD_HI, 13'($urandom));
            send(OP_BEGIN, 8'($urandom));
            npix = clamp_dim(13'(w)) * clamp_dim(13'(h));
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, npix - 1) : npix;
            for (int i = 0; i < cut; i++) send(OP_PIXEL, 8'($urandom));
            if (cut != npix) begin
                abandons++;
                send(OP_BEGIN, 8'($urandom));
                for (int i = 0; i < npix; i++) send(OP_PIXEL, 8'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                strays++;
                send(OP_PIXEL, 8'($urandom));
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests, %0d output bytes, %0d complete images", items,
                 bytes_seen, frames_done);
        $display("%0d abandoned images, %0d stray pixels", abandons, strays);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
